>>> rtl/wsp_pkg.sv
// wsp_pkg: widths, register codes, reset values and shared types of the
// world-to-screen projection pipeline. No dependencies.
package wsp_pkg;

	localparam int COEF_W    = 21;
	localparam int ROW_W     = 63;
	localparam int DIM_W     = 14;
	localparam int IN_W      = 24;
	localparam int OUT_W     = 20;
	localparam int CFG_IDX_W = 3;

	// clip = sum of three Q14.10*Q11.10 products plus a Q11.10 bias shifted by 10
	localparam int PROD_W  = IN_W + COEF_W;
	localparam int BIAS_W  = COEF_W + 10;
	localparam int CLIP_W  = 47;
	localparam int MAG_W   = CLIP_W - 1;
	localparam int FRAC_SH = 16;
	localparam int NUM_W   = MAG_W + FRAC_SH;
	localparam int QW      = 37;
	localparam int NDC_W   = 38;
	localparam int MAP_W   = NDC_W + 1;
	localparam int MPROD_W = MAP_W + DIM_W + 1;
	localparam int PIX_SH  = 13;
	localparam int W0_SH   = 4;

	localparam logic signed [NDC_W-1:0] NDC_MAX = NDC_W'(64'sd68719476736);
	localparam logic signed [NDC_W-1:0] NDC_MIN = -NDC_MAX;
	localparam logic signed [MAP_W-1:0] NDC_ONE = MAP_W'(65536);

	localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(524287);
	localparam logic signed [OUT_W-1:0] OUT_MIN = OUT_W'(-524288);

	localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(64'd1024);
	localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(64'd2147483648);
	localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(64'd0);
	localparam logic [ROW_W-1:0] ROW3_RST = ROW_W'(64'd4503599627370496);
	localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1280);
	localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(720);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW0   = 3'd0,
		CFG_ROW1   = 3'd1,
		CFG_ROW2   = 3'd2,
		CFG_ROW3   = 3'd3,
		CFG_WIDTH  = 3'd4,
		CFG_HEIGHT = 3'd5
	} cfg_idx_t;

	// per-item info that rides alongside the divider stages
	typedef struct packed {
		logic                    qneg_x;
		logic                    ovf_x;
		logic                    qneg_y;
		logic                    ovf_y;
		logic                    w0;
		logic signed [NDC_W-1:0] ndc0_x;
		logic signed [NDC_W-1:0] ndc0_y;
	} side_t;

	function automatic logic signed [COEF_W-1:0] coef(input logic [ROW_W-1:0] row,
		input int unsigned slot);
		return $signed(row[slot*COEF_W +: COEF_W]);
	endfunction

endpackage

>>> rtl/wsp_cfg_if.sv
// wsp_cfg_if: register write channel (index and data).
// Depends on wsp_pkg.
interface wsp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [wsp_pkg::CFG_IDX_W-1:0] index;
	logic [wsp_pkg::ROW_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/wsp_point_if.sv
// wsp_point_if: world point channel, signed Q14.10 coordinates.
// Depends on wsp_pkg.
interface wsp_point_if;
	logic                             valid;
	logic                             ready;
	logic signed [wsp_pkg::IN_W-1:0] world_x;
	logic signed [wsp_pkg::IN_W-1:0] world_y;
	logic signed [wsp_pkg::IN_W-1:0] world_z;

	modport source (output valid, world_x, world_y, world_z, input ready);
	modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

>>> rtl/wsp_pixel_if.sv
// wsp_pixel_if: pixel result channel, signed Q16.4 position and flags.
// Depends on wsp_pkg.
interface wsp_pixel_if;
	logic                              valid;
	logic                              ready;
	logic signed [wsp_pkg::OUT_W-1:0] screen_x;
	logic signed [wsp_pkg::OUT_W-1:0] screen_y;
	logic                              w_was_zero;
	logic                              clipped_flag;

	modport source (output valid, screen_x, screen_y, w_was_zero, clipped_flag, input ready);
	modport sink (input valid, screen_x, screen_y, w_was_zero, clipped_flag, output ready);
endinterface

>>> rtl/world_to_screen_projection.sv
// channel  | dir | payload
// ---------+-----+----------------------------------------------------
// cfg      | in  | index (3b), data (63b); always ready
// point    | in  | world_x, world_y, world_z (signed Q14.10)
// pixel    | out | screen_x, screen_y (signed Q16.4), w_was_zero, clipped_flag
//
// one point per cycle while the output register is empty or taken; 3 matrix stages,
// 37 divider stages and 3 mapping stages with the output register last
// the whole pipeline advances together whenever the output register is empty or taken
// arst_n clears all valid bits and loads the identity matrix and a 1280x720 viewport
// world_to_screen_projection: top level. Depends on wsp_pkg, the wsp_*_if interfaces
// and wsp_div.
module world_to_screen_projection (
	input  logic           clk,
	input  logic           arst_n,
	wsp_cfg_if.sink        cfg,
	wsp_point_if.sink      point,
	wsp_pixel_if.source    pixel
);
	localparam int CLIP_W  = wsp_pkg::CLIP_W;
	localparam int MAG_W   = wsp_pkg::MAG_W;
	localparam int NUM_W   = wsp_pkg::NUM_W;
	localparam int QW      = wsp_pkg::QW;
	localparam int NDC_W   = wsp_pkg::NDC_W;
	localparam int MAP_W   = wsp_pkg::MAP_W;
	localparam int MPROD_W = wsp_pkg::MPROD_W;
	localparam int OUT_W   = wsp_pkg::OUT_W;
	localparam int DEPTH   = QW + 6;

	logic [wsp_pkg::ROW_W-1:0] row_q [4];
	logic [wsp_pkg::DIM_W-1:0] width_q;
	logic [wsp_pkg::DIM_W-1:0] height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= wsp_pkg::ROW0_RST;
			row_q[1] <= wsp_pkg::ROW1_RST;
			row_q[2] <= wsp_pkg::ROW2_RST;
			row_q[3] <= wsp_pkg::ROW3_RST;
			width_q  <= wsp_pkg::WIDTH_RST;
			height_q <= wsp_pkg::HEIGHT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				wsp_pkg::CFG_ROW0:   row_q[0] <= cfg.data;
				wsp_pkg::CFG_ROW1:   row_q[1] <= cfg.data;
				wsp_pkg::CFG_ROW2:   row_q[2] <= cfg.data;
				wsp_pkg::CFG_ROW3:   row_q[3] <= cfg.data;
				wsp_pkg::CFG_WIDTH:  width_q  <= cfg.data[wsp_pkg::DIM_W-1:0];
				wsp_pkg::CFG_HEIGHT: height_q <= cfg.data[wsp_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// global advance
	logic en;
	logic vld_q [DEPTH];

	assign en          = ~vld_q[DEPTH-1] | pixel.ready;
	assign point.ready = en;
	assign pixel.valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= point.valid;
			for (int i = 1; i < DEPTH; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// s1: nine products and three biases (slot 2 is matrix column 3)
	logic signed [wsp_pkg::PROD_W-1:0] prod_s1 [3][3];
	logic signed [wsp_pkg::BIAS_W-1:0] bias_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < 3; s++) begin
				prod_s1[s][0] <= point.world_x * wsp_pkg::coef(row_q[0], s);
				prod_s1[s][1] <= point.world_y * wsp_pkg::coef(row_q[1], s);
				prod_s1[s][2] <= point.world_z * wsp_pkg::coef(row_q[2], s);
				bias_s1[s]    <= $signed({wsp_pkg::coef(row_q[3], s), 10'b0});
			end
		end
	end

	// s2: clip x, y, w in Q.20
	logic signed [CLIP_W-1:0] clip_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < 3; s++) begin
				clip_s2[s] <= CLIP_W'(prod_s1[s][0]) + CLIP_W'(prod_s1[s][1])
					+ CLIP_W'(prod_s1[s][2]) + CLIP_W'(bias_s1[s]);
			end
		end
	end

	// s3: magnitudes, signs, overflow check, undivided fallback
	logic signed [CLIP_W-1:0] neg_x, neg_y, neg_w, sh_x, sh_y;
	logic [MAG_W-1:0]         mag_x, mag_y, mag_w;
	logic [NUM_W-1:0]         num_x, num_y;
	wsp_pkg::side_t           side_c;

	function automatic logic signed [NDC_W-1:0] clamp_ndc(input logic signed [CLIP_W-1:0] v);
		if (v > CLIP_W'(wsp_pkg::NDC_MAX)) return wsp_pkg::NDC_MAX;
		else if (v < CLIP_W'(wsp_pkg::NDC_MIN)) return wsp_pkg::NDC_MIN;
		else return v[NDC_W-1:0];
	endfunction

	always_comb begin
		neg_x = -clip_s2[0];
		neg_y = -clip_s2[1];
		neg_w = -clip_s2[2];
		mag_x = clip_s2[0][CLIP_W-1] ? neg_x[MAG_W-1:0] : clip_s2[0][MAG_W-1:0];
		mag_y = clip_s2[1][CLIP_W-1] ? neg_y[MAG_W-1:0] : clip_s2[1][MAG_W-1:0];
		mag_w = clip_s2[2][CLIP_W-1] ? neg_w[MAG_W-1:0] : clip_s2[2][MAG_W-1:0];
		num_x = {mag_x, {wsp_pkg::FRAC_SH{1'b0}}};
		num_y = {mag_y, {wsp_pkg::FRAC_SH{1'b0}}};
		sh_x  = clip_s2[0] >>> wsp_pkg::W0_SH;
		sh_y  = clip_s2[1] >>> wsp_pkg::W0_SH;

		side_c.qneg_x = clip_s2[0][CLIP_W-1] ^ clip_s2[2][CLIP_W-1];
		side_c.qneg_y = clip_s2[1][CLIP_W-1] ^ clip_s2[2][CLIP_W-1];
		// quotient would reach 2^37 or more: result is clamped anyway
		side_c.ovf_x  = MAG_W'(num_x[NUM_W-1:QW]) >= mag_w;
		side_c.ovf_y  = MAG_W'(num_y[NUM_W-1:QW]) >= mag_w;
		side_c.w0     = clip_s2[2] == '0;
		side_c.ndc0_x = clamp_ndc(sh_x);
		side_c.ndc0_y = clamp_ndc(sh_y);
	end

	logic [NUM_W-1:0] num_x_s3, num_y_s3;
	logic [MAG_W-1:0] den_s3;
	wsp_pkg::side_t   side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s3 <= num_x;
			num_y_s3 <= num_y;
			den_s3   <= mag_w;
			side_s3  <= side_c;
		end
	end

	// divider stages
	logic [QW-1:0] quo_x, quo_y;
	logic          rnz_x, rnz_y;

	wsp_div u_div_x (
		.clk    (clk),
		.en     (en),
		.num    (num_x_s3),
		.den    (den_s3),
		.quo    (quo_x),
		.rem_nz (rnz_x)
	);

	wsp_div u_div_y (
		.clk    (clk),
		.en     (en),
		.num    (num_y_s3),
		.den    (den_s3),
		.quo    (quo_y),
		.rem_nz (rnz_y)
	);

	wsp_pkg::side_t side_q [QW];

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s3;
			for (int i = 1; i < QW; i++) side_q[i] <= side_q[i-1];
		end
	end

	// s4: signed floor quotient (or the undivided fallback when w is zero), clamped ndc in Q.16
	function automatic logic signed [NDC_W-1:0] fix_ndc(input logic [QW-1:0] q,
		input logic rnz, input logic qneg, input logic ovf, input logic w0,
		input logic signed [NDC_W-1:0] ndc0);
		logic signed [MAP_W-1:0] qs;
		logic signed [MAP_W-1:0] v;
		qs = $signed({2'b00, q});
		v  = qneg ? (-qs - MAP_W'(rnz)) : qs;
		if (w0) return ndc0;
		else if (ovf) return qneg ? wsp_pkg::NDC_MIN : wsp_pkg::NDC_MAX;
		else if (v > MAP_W'(wsp_pkg::NDC_MAX)) return wsp_pkg::NDC_MAX;
		else if (v < MAP_W'(wsp_pkg::NDC_MIN)) return wsp_pkg::NDC_MIN;
		else return v[NDC_W-1:0];
	endfunction

	logic signed [NDC_W-1:0] ndc_x_s4, ndc_y_s4;
	logic                    w0_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ndc_x_s4 <= fix_ndc(quo_x, rnz_x, side_q[QW-1].qneg_x, side_q[QW-1].ovf_x,
				side_q[QW-1].w0, side_q[QW-1].ndc0_x);
			ndc_y_s4 <= fix_ndc(quo_y, rnz_y, side_q[QW-1].qneg_y, side_q[QW-1].ovf_y,
				side_q[QW-1].w0, side_q[QW-1].ndc0_y);
			w0_s4    <= side_q[QW-1].w0;
		end
	end

	// s5: viewport scale
	logic signed [MAP_W-1:0]   ax, ay;
	logic signed [MPROD_W-1:0] px_s5, py_s5;
	logic                      w0_s5;

	assign ax = MAP_W'(ndc_x_s4) + wsp_pkg::NDC_ONE;
	assign ay = wsp_pkg::NDC_ONE - MAP_W'(ndc_y_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			px_s5 <= MPROD_W'(ax) * MPROD_W'($signed({1'b0, width_q}));
			py_s5 <= MPROD_W'(ay) * MPROD_W'($signed({1'b0, height_q}));
			w0_s5 <= w0_s4;
		end
	end

	// s6: floor to Q16.4 and saturate into the output register
	logic signed [MPROD_W-1:0] fx, fy;
	logic signed [OUT_W-1:0]   cx, cy;
	logic                      sat_x, sat_y;

	always_comb begin
		fx    = px_s5 >>> wsp_pkg::PIX_SH;
		fy    = py_s5 >>> wsp_pkg::PIX_SH;
		sat_x = (fx > MPROD_W'(wsp_pkg::OUT_MAX)) || (fx < MPROD_W'(wsp_pkg::OUT_MIN));
		sat_y = (fy > MPROD_W'(wsp_pkg::OUT_MAX)) || (fy < MPROD_W'(wsp_pkg::OUT_MIN));
		cx    = sat_x ? (fx[MPROD_W-1] ? wsp_pkg::OUT_MIN : wsp_pkg::OUT_MAX) : fx[OUT_W-1:0];
		cy    = sat_y ? (fy[MPROD_W-1] ? wsp_pkg::OUT_MIN : wsp_pkg::OUT_MAX) : fy[OUT_W-1:0];
	end

	logic signed [OUT_W-1:0] sx_s6, sy_s6;
	logic                    w0_s6, clip_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s6   <= cx;
			sy_s6   <= cy;
			w0_s6   <= w0_s5;
			clip_s6 <= sat_x | sat_y;
		end
	end

	assign pixel.screen_x     = sx_s6;
	assign pixel.screen_y     = sy_s6;
	assign pixel.w_was_zero   = w0_s6;
	assign pixel.clipped_flag = clip_s6;
endmodule

>>> rtl/wsp_div.sv
// wsp_div: pipelined restoring divider, one quotient bit per stage, QW stages.
// Depends on wsp_pkg. Caller guarantees num[NUM_W-1:QW] < den for a valid quotient.
module wsp_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [wsp_pkg::NUM_W-1:0]   num,
	input  logic [wsp_pkg::MAG_W-1:0]   den,
	output logic [wsp_pkg::QW-1:0]      quo,
	output logic                         rem_nz
);
	localparam int QW    = wsp_pkg::QW;
	localparam int MAG_W = wsp_pkg::MAG_W;
	localparam int NUM_W = wsp_pkg::NUM_W;

	logic [MAG_W-1:0] rem_q [QW];
	logic [QW-1:0]    low_q [QW];
	logic [QW-1:0]    quo_q [QW];
	logic [MAG_W-1:0] den_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [MAG_W-1:0] rem_in;
		logic [QW-1:0]    low_in;
		logic [QW-1:0]    quo_in;
		logic [MAG_W-1:0] den_in;
		logic [MAG_W:0]   trial;
		logic [MAG_W:0]   diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = MAG_W'(num[NUM_W-1:QW]);
			assign low_in = num[QW-1:0];
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign low_in = low_q[k-1];
			assign quo_in = quo_q[k-1];
			assign den_in = den_q[k-1];
		end

		assign trial = {rem_in, low_in[QW-1]};
		assign diff  = trial - {1'b0, den_in};
		// no borrow means the trial remainder covers the divisor
		assign ge    = ~diff[MAG_W];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
				low_q[k] <= {low_in[QW-2:0], 1'b0};
				quo_q[k] <= {quo_in[QW-2:0], ge};
				den_q[k] <= den_in;
			end
		end
	end

	assign quo    = quo_q[QW-1];
	assign rem_nz = |rem_q[QW-1];
endmodule

>>> verif/wsp_projection_checker.sv
`timescale 1ns / 100ps
// wsp_projection_checker: watches the register, point and pixel channels of the
// projection block, predicts every pixel and compares.
// Depends on wsp_pkg and the wsp_*_if interfaces.
module wsp_projection_checker (
	input  logic  clk,
	input  logic  arst_n,
	wsp_cfg_if    cfg,
	wsp_point_if  point,
	wsp_pixel_if  pixel,
	output int    mismatches,
	output int    pending
);

	localparam longint NDC_LIM = 64'sd68719476736;
	localparam longint ONE_Q16 = 64'sd65536;

	typedef struct {
		logic signed [wsp_pkg::OUT_W-1:0] sx;
		logic signed [wsp_pkg::OUT_W-1:0] sy;
		logic                             w0;
		logic                             clip;
	} pixel_t;

	logic [wsp_pkg::ROW_W-1:0] mat_row [4];
	logic [wsp_pkg::DIM_W-1:0] view_w;
	logic [wsp_pkg::DIM_W-1:0] view_h;
	pixel_t                    expected_px [$];

	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d != 0) && ((n < 0) != (d < 0)))
			q--;
		return q;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// slot 0, 1, 2 hold matrix columns 0, 1, 3
	function automatic longint entry(logic [wsp_pkg::ROW_W-1:0] r, int s);
		logic signed [wsp_pkg::COEF_W-1:0] c;
		c = r[s*wsp_pkg::COEF_W +: wsp_pkg::COEF_W];
		return longint'(c);
	endfunction

	function automatic pixel_t project(logic signed [wsp_pkg::IN_W-1:0] wx,
		logic signed [wsp_pkg::IN_W-1:0] wy, logic signed [wsp_pkg::IN_W-1:0] wz);
		longint x, y, z, sx, sy, csx, csy;
		longint clip_v [3];
		longint ndc [2];
		pixel_t p;
		x = wx;
		y = wy;
		z = wz;
		for (int s = 0; s < 3; s++)
			clip_v[s] = x * entry(mat_row[0], s) + y * entry(mat_row[1], s)
				+ z * entry(mat_row[2], s) + entry(mat_row[3], s) * 1024;
		for (int a = 0; a < 2; a++) begin
			if (clip_v[2] != 0)
				ndc[a] = floor_div(clip_v[a] * ONE_Q16, clip_v[2]);
			else
				ndc[a] = floor_div(clip_v[a], 16);
			ndc[a] = clamp(ndc[a], -NDC_LIM, NDC_LIM);
		end
		sx = floor_div((ndc[0] + ONE_Q16) * longint'(view_w), 8192);
		sy = floor_div((ONE_Q16 - ndc[1]) * longint'(view_h), 8192);
		csx = clamp(sx, -524288, 524287);
		csy = clamp(sy, -524288, 524287);
		p.sx = csx[wsp_pkg::OUT_W-1:0];
		p.sy = csy[wsp_pkg::OUT_W-1:0];
		p.w0 = (clip_v[2] == 0);
		p.clip = (csx != sx) || (csy != sy);
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_t e;
		if (!arst_n) begin
			mat_row[0] <= wsp_pkg::ROW0_RST;
			mat_row[1] <= wsp_pkg::ROW1_RST;
			mat_row[2] <= wsp_pkg::ROW2_RST;
			mat_row[3] <= wsp_pkg::ROW3_RST;
			view_w <= wsp_pkg::WIDTH_RST;
			view_h <= wsp_pkg::HEIGHT_RST;
			expected_px.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (point.valid && point.ready)
				expected_px.push_back(project(point.world_x, point.world_y, point.world_z));
			if (pixel.valid && pixel.ready) begin
				if (expected_px.size() == 0) begin
					if (mismatches < 10)
						$display("pixel transaction with nothing expected: x=%0d y=%0d",
							pixel.screen_x, pixel.screen_y);
					mismatches <= mismatches + 1;
				end else begin
					e = expected_px.pop_front();
					if (e.sx !== pixel.screen_x || e.sy !== pixel.screen_y
						|| e.w0 !== pixel.w_was_zero || e.clip !== pixel.clipped_flag) begin
						if (mismatches < 10)
							$display({"pixel mismatch: expected x=%0d y=%0d w0=%0b clip=%0b,",
								" got x=%0d y=%0d w0=%0b clip=%0b"},
								e.sx, e.sy, e.w0, e.clip, pixel.screen_x, pixel.screen_y,
								pixel.w_was_zero, pixel.clipped_flag);
						mismatches <= mismatches + 1;
					end
				end
			end
			pending <= expected_px.size();
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					wsp_pkg::CFG_ROW0:   mat_row[0] <= cfg.data;
					wsp_pkg::CFG_ROW1:   mat_row[1] <= cfg.data;
					wsp_pkg::CFG_ROW2:   mat_row[2] <= cfg.data;
					wsp_pkg::CFG_ROW3:   mat_row[3] <= cfg.data;
					wsp_pkg::CFG_WIDTH:  view_w <= cfg.data[wsp_pkg::DIM_W-1:0];
					wsp_pkg::CFG_HEIGHT: view_h <= cfg.data[wsp_pkg::DIM_W-1:0];
					default:    ;
				endcase
			end
		end
	end

endmodule

>>> verif/world_to_screen_projection_tb.sv
`timescale 1ns / 100ps
// world_to_screen_projection_tb: clock, reset, register setup, point stimulus and
// output stalls; depends on wsp_pkg, the wsp_*_if interfaces and wsp_projection_checker.
module world_to_screen_projection_tb;

	localparam logic [wsp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd6;
	localparam logic [wsp_pkg::CFG_IDX_W-1:0] CFG_TOP   = 3'd7;
	localparam int Q_ONE = 1024;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   cycles;
	bit   quiet;
	int   stall_left;

	wsp_cfg_if   cfg ();
	wsp_point_if point ();
	wsp_pixel_if pixel ();

	world_to_screen_projection dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .point(point), .pixel(pixel)
	);

	wsp_projection_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .point(point), .pixel(pixel),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic [wsp_pkg::ROW_W-1:0] row(int c0, int c1, int c3);
		logic [wsp_pkg::COEF_W-1:0] a, b, c;
		a = wsp_pkg::COEF_W'(c0);
		b = wsp_pkg::COEF_W'(c1);
		c = wsp_pkg::COEF_W'(c3);
		return {c, b, a};
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// output stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			pixel.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			pixel.ready <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	task automatic write_reg(logic [wsp_pkg::CFG_IDX_W-1:0] idx,
		logic [wsp_pkg::ROW_W-1:0] v);
		bit taken;
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		do begin
			@(negedge clk);
			taken = cfg.ready;
			@(posedge clk);
		end while (!taken);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_point(int x, int y, int z);
		int gap;
		bit taken;
		gap = pick_gap();
		if (gap > 0) begin
			point.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point.valid <= 1'b1;
		point.world_x <= wsp_pkg::IN_W'(x);
		point.world_y <= wsp_pkg::IN_W'(y);
		point.world_z <= wsp_pkg::IN_W'(z);
		do begin
			@(negedge clk);
			taken = point.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// wait for all pixels, then let the pipeline drain
	task automatic settle();
		point.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_view(int w, int h);
		write_reg(wsp_pkg::CFG_WIDTH, wsp_pkg::ROW_W'(w));
		write_reg(wsp_pkg::CFG_HEIGHT, wsp_pkg::ROW_W'(h));
	endtask

	function automatic logic [wsp_pkg::ROW_W-1:0] rand_row(int mode);
		int span;
		span = (mode == 0) ? (1 << 20) : (1 << 12);
		if (mode == 0 && $urandom_range(3) == 0)
			return wsp_pkg::ROW_W'({$urandom(), $urandom()});
		return row($urandom_range(span - 1) - span / 2, $urandom_range(span - 1) - span / 2,
			$urandom_range(span - 1) - span / 2);
	endfunction

	function automatic int pick_dim();
		case ($urandom_range(7))
			0: return 0;
			1: return 1;
			2: return 8192;
			3: return 16383;
			4: return 1280;
			default: return $urandom_range(16383);
		endcase
	endfunction

	function automatic int pick_coord();
		if ($urandom_range(2) == 0)
			return $urandom_range(32767) - 16384;
		return $urandom_range(24'hFFFFFF) - 24'h800000;
	endfunction

	initial begin
		int wmode;
		logic [wsp_pkg::ROW_W-1:0] r3;
		arst_n = 1'b0;
		quiet = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		point.valid = 1'b0;
		point.world_x = '0;
		point.world_y = '0;
		point.world_z = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset matrix: origin, extremes, saturation
		send_point(0, 0, 0);
		send_point(Q_ONE / 2, -Q_ONE / 2, Q_ONE);
		send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
		send_point(-8388608, -8388608, -8388608);
		send_point(-1, -1, -1);
		send_point(-8388608, 8388607, 0);
		settle();

		// column 3 all zero: w is zero, undivided path
		write_reg(wsp_pkg::CFG_ROW0, row(Q_ONE, 0, 0));
		write_reg(wsp_pkg::CFG_ROW1, row(0, Q_ONE, 0));
		write_reg(wsp_pkg::CFG_ROW3, row(0, 0, 0));
		send_point(0, 0, 0);
		send_point(Q_ONE, -Q_ONE, 5);
		send_point(8388607, -8388608, 77);
		settle();

		// perspective w = z with a tiny bias: huge ndc, negative w, w exactly zero
		write_reg(wsp_pkg::CFG_ROW2, row(0, 0, Q_ONE));
		write_reg(wsp_pkg::CFG_ROW3, row(0, 0, 1));
		send_point(Q_ONE, Q_ONE, 0);
		send_point(8388607, 8388607, -1);
		send_point(-Q_ONE, Q_ONE, -2 * Q_ONE);
		send_point(Q_ONE, Q_ONE, Q_ONE);
		settle();

		// viewport extremes, extreme coefficients, writes to unused indexes
		write_reg(wsp_pkg::CFG_ROW0, row(-1048576, 1048575, -1048576));
		write_reg(CFG_SPARE, '1);
		write_reg(CFG_TOP, '1);
		set_view(0, 16383);
		send_point(Q_ONE, -Q_ONE, Q_ONE);
		send_point(-3, 7, 2 * Q_ONE);
		settle();
		set_view(16383, 0);
		send_point(Q_ONE, -Q_ONE, Q_ONE);
		settle();
		set_view(1, 8192);
		send_point(Q_ONE / 4, Q_ONE / 3, Q_ONE);
		send_point(0, -8388608, 8388607);
		settle();

		for (int ph = 0; ph < 12; ph++) begin
			wmode = $urandom_range(2);
			quiet = (ph % 4 == 3);
			write_reg(wsp_pkg::CFG_ROW0, rand_row(ph % 2));
			write_reg(wsp_pkg::CFG_ROW1, rand_row(ph % 2));
			if (wmode == 2) begin
				write_reg(wsp_pkg::CFG_ROW2, row($urandom_range(255), $urandom_range(255),
					Q_ONE + $urandom_range(511) - 256));
				r3 = row($urandom_range(8191), $urandom_range(8191), $urandom_range(31));
			end else begin
				write_reg(wsp_pkg::CFG_ROW2, rand_row(ph % 2));
				r3 = rand_row(ph % 2);
			end
			if (wmode == 1) begin
				r3[wsp_pkg::ROW_W-1 -: wsp_pkg::COEF_W] = '0;
				write_reg(wsp_pkg::CFG_ROW2,
					row($urandom_range(4095), $urandom_range(4095), 0));
			end
			write_reg(wsp_pkg::CFG_ROW3, r3);
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? CFG_SPARE : CFG_TOP,
					wsp_pkg::ROW_W'({$urandom(), $urandom()}));
			set_view(pick_dim(), pick_dim());
			for (int i = 0; i < 162; i++) begin
				if (wmode != 0 && $urandom_range(9) == 0)
					send_point(pick_coord(), pick_coord(), 0);
				else
					send_point(pick_coord(), pick_coord(), pick_coord());
			end
			settle();
		end

		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
